[hdl/nntbc_pkg.sv]
package nntbc_pkg;

  localparam int MaxItems = 64;
  localparam int MaxDims = 8;
  localparam int IdxW = $clog2(MaxItems);
  localparam int CntW = $clog2(MaxItems + 1);
  localparam int DimW = $clog2(MaxDims + 1);
  localparam int DimIdxW = (MaxDims > 1) ? $clog2(MaxDims) : 1;
  localparam int PtAddrW = IdxW + DimIdxW;
  localparam int LoadW = 30;
  localparam int DistW = 36;
  localparam int StageW = 6;
  localparam int NumStagesW = 7;
  localparam int CfgW = 7;
  localparam int QuoW = 30;

  localparam logic CfgNumStages = 1'b0;
  localparam logic CfgNumDims = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_DIV,
    ST_TOUR_INIT,
    ST_SCAN,
    ST_DIM,
    ST_ACC,
    ST_PICK,
    ST_CUT_RD,
    ST_CUT_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic tour_init;
    logic scan_start;
    logic dim_rd;
    logic acc;
    logic cand_done;
    logic pick;
    logic cut_rd;
    logic cut_eval;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic dim_last;
    logic cand_visited;
    logic cand_last;
    logic tour_last;
    logic emit_last;
  } status_t;

endpackage

[hdl/nntbc_ctrl.sv]
module nntbc_ctrl
  import nntbc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  input  logic    out_stall,
  input  status_t sts,
  output logic    in_stall,
  output logic    out_valid,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_next = ST_DIV;
            cmd.div_start = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (!sts.div_busy) begin
          cmd.tour_init = 1'b1;
          state_next = sts.tour_last ? ST_CUT_RD : ST_TOUR_INIT;
        end
      end
      ST_TOUR_INIT: begin
        cmd.scan_start = 1'b1;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.cand_visited) begin
          cmd.cand_done = 1'b1;
          state_next = sts.cand_last ? ST_PICK : ST_SCAN;
        end else begin
          cmd.dim_rd = 1'b1;
          state_next = ST_DIM;
        end
      end
      ST_DIM: begin
        cmd.dim_rd = !sts.dim_last;
        cmd.acc = 1'b1;
        state_next = sts.dim_last ? ST_ACC : ST_DIM;
      end
      ST_ACC: begin
        cmd.cand_done = 1'b1;
        state_next = sts.cand_last ? ST_PICK : ST_SCAN;
      end
      ST_PICK: begin
        cmd.pick = 1'b1;
        state_next = sts.tour_last ? ST_CUT_RD : ST_TOUR_INIT;
      end
      ST_CUT_RD: begin
        cmd.cut_rd = 1'b1;
        state_next = ST_CUT_WAIT;
      end
      ST_CUT_WAIT: begin
        cmd.cut_eval = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.emit_done = 1'b1;
          state_next = sts.emit_last ? ST_LOAD : ST_CUT_RD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule

[hdl/nntbc_dp.sv]
module nntbc_dp
  import nntbc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [CfgW-1:0]         cfg_data,
  input  logic [23:0]             runtime,
  input  logic [MaxDims-1:0][15:0] coords,
  output status_t                 sts,
  output logic [6:0]              job_number,
  output logic [StageW-1:0]       stage,
  output logic                    stage_end,
  output logic                    last_result
);

  logic [NumStagesW-1:0] num_stages;
  logic [3:0] num_dims;
  logic [23:0] rt_mem [MaxItems];
  logic [MaxDims-1:0][15:0] pt_mem [MaxItems];
  logic [IdxW-1:0] tour_mem [MaxItems];
  logic [MaxItems-1:0] visited;
  logic [CntW-1:0] job_count;
  logic [LoadW-1:0] total_load;
  logic [LoadW-1:0] seg_load;
  logic [StageW:0] cur_stage;
  logic [NumStagesW-1:0] stages;
  logic [DimW-1:0] dims;

  logic [IdxW-1:0] cur, cand, best_idx;
  logic [DistW-1:0] best, dist_acc;
  logic found;
  logic [CntW-1:0] tour_pos;
  logic [DimW-1:0] dim_cnt;
  logic [MaxDims-1:0][15:0] pt_a, pt_b;
  logic [DimIdxW-1:0] dim_sel;
  logic signed [16:0] diff;
  logic pt_valid;
  logic [16:0] absd;
  logic absd_valid;
  logic [33:0] sq;
  logic sq_valid;

  logic [QuoW-1:0] quo;
  logic [LoadW:0] rem;
  logic [LoadW-1:0] dividend;
  logic [4:0] div_cnt;
  logic div_busy;
  logic [LoadW-1:0] target;

  logic [CntW-1:0] emit_pos;
  logic [IdxW-1:0] emit_job;
  logic [23:0] emit_rt;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_stages <= NumStagesW'(1);
      num_dims <= 4'd1;
    end else if (cfg_we) begin
      if (cfg_index == CfgNumStages) begin
        num_stages <= cfg_data;
      end else begin
        num_dims <= cfg_data[3:0];
      end
    end
  end

  always_comb begin
    if (num_stages == '0) begin
      stages = NumStagesW'(1);
    end else if (num_stages > NumStagesW'(64)) begin
      stages = NumStagesW'(64);
    end else begin
      stages = num_stages;
    end
    dims = (num_dims > 4'(MaxDims)) ? DimW'(MaxDims) : DimW'(num_dims);
  end

  // Each job's point is stored as one word holding all its coordinates.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rt_mem[job_count[IdxW-1:0]] <= runtime;
      pt_mem[job_count[IdxW-1:0]] <= coords;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_count <= '0;
      total_load <= '0;
    end else if (cmd.load) begin
      job_count <= job_count + CntW'(1);
      total_load <= total_load + LoadW'(runtime);
    end else if (cmd.emit_done && sts.emit_last) begin
      job_count <= '0;
      total_load <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy <= 1'b1;
      div_cnt <= 5'(LoadW - 1);
      rem <= '0;
      quo <= '0;
      dividend <= total_load + LoadW'(runtime) + LoadW'(stages) - LoadW'(1);
    end else if (div_busy) begin
      logic [LoadW:0] trial;
      trial = {rem[LoadW-1:0], dividend[div_cnt]};
      if (trial >= (LoadW+1)'(stages)) begin
        rem <= trial - (LoadW+1)'(stages);
        quo <= {quo[QuoW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[QuoW-2:0], 1'b0};
      end
      if (div_cnt == '0) begin
        div_busy <= 1'b0;
      end
      div_cnt <= div_cnt - 5'd1;
    end
  end
  assign target = quo;

  always_ff @(posedge clk) begin
    pt_a <= pt_mem[cur];
    pt_b <= pt_mem[cand];
    dim_sel <= dim_cnt[DimIdxW-1:0];
    absd <= diff[16] ? 17'(-diff) : 17'(diff);
    sq <= 34'(absd) * 34'(absd);
  end

  always_comb begin
    diff = $signed({pt_a[dim_sel][15], pt_a[dim_sel]}) -
           $signed({pt_b[dim_sel][15], pt_b[dim_sel]});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
      absd_valid <= 1'b0;
      sq_valid <= 1'b0;
    end else begin
      pt_valid <= cmd.dim_rd && (dim_cnt < dims);
      absd_valid <= pt_valid;
      sq_valid <= absd_valid;
    end
  end

  logic [DistW-1:0] dist_sum;
  always_comb begin
    dist_sum = dist_acc + (sq_valid ? DistW'(sq) : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
    end else begin
      if (cmd.tour_init) begin
        visited <= MaxItems'(1);
      end else if (cmd.pick) begin
        visited[best_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      tour_pos <= '0;
    end else if (cmd.tour_init) begin
      cur <= '0;
      tour_pos <= CntW'(1);
      tour_mem[0] <= '0;
    end else if (cmd.pick) begin
      tour_mem[tour_pos[IdxW-1:0]] <= best_idx;
      cur <= best_idx;
      tour_pos <= tour_pos + CntW'(1);
    end
  end

  // A candidate's squared distance accumulates while the read pipeline drains.
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      cand <= '0;
      found <= 1'b0;
      dim_cnt <= '0;
      dist_acc <= '0;
    end else if (cmd.cand_done) begin
      if (!sts.cand_visited && (!found || dist_acc < best)) begin
        best <= dist_acc;
        best_idx <= cand;
        found <= 1'b1;
      end
      cand <= cand + IdxW'(1);
      dim_cnt <= '0;
      dist_acc <= '0;
    end else begin
      if (cmd.dim_rd) begin
        dim_cnt <= dim_cnt + DimW'(1);
      end
      if (cmd.acc) begin
        dist_acc <= dist_sum;
      end
    end
  end

  always_comb begin
    sts.div_busy = div_busy;
    sts.dim_last = (dim_cnt == dims + DimW'(2));
    sts.cand_visited = visited[cand];
    sts.cand_last = ({1'b0, cand} == CntW'(job_count - CntW'(1)));
    sts.tour_last = ((tour_pos + CntW'(1)) == job_count);
    sts.emit_last = (emit_pos == CntW'(job_count - CntW'(1)));
  end

  always_ff @(posedge clk) begin
    if (cmd.tour_init) begin
      emit_pos <= '0;
      seg_load <= '0;
      cur_stage <= '0;
    end else if (cmd.emit_done) begin
      emit_pos <= emit_pos + CntW'(1);
      if (stage_end && !last_result) begin
        seg_load <= '0;
        cur_stage <= cur_stage + 7'd1;
      end else begin
        seg_load <= seg_load + LoadW'(emit_rt);
      end
    end
    if (cmd.cut_rd) begin
      emit_job <= tour_mem[emit_pos[IdxW-1:0]];
    end
    if (cmd.cut_eval) begin
      emit_rt <= rt_mem[emit_job];
    end
  end

  logic [LoadW-1:0] seg_now;
  logic cut;
  always_comb begin
    seg_now = seg_load + LoadW'(emit_rt);
    cut = (cur_stage < 7'(stages - NumStagesW'(1))) && (seg_now >= target) &&
          (7'(job_count - CntW'(1) - emit_pos) > 7'(stages - NumStagesW'(1) - cur_stage));
    job_number = 7'(emit_job) + 7'd1;
    stage = cur_stage[StageW-1:0];
    last_result = sts.emit_last;
    stage_end = cut || last_result;
  end

endmodule

[hdl/nearest_neighbor_tour_balanced_cut.sv]
// Loads up to 64 jobs, one per cycle; a word with last_job set (or the 64th job) starts a run.
// A run first divides the total load by the stage count (rounded up) for the stage target, then
// for each tour step scans all loaded jobs, skipping a visited job and summing squared coordinate
// differences over the configured dims for an unvisited one, and finally emits the result words
// while the output is not stalled.
// Input is stalled during the whole run; configuration is read throughout the run.
module nearest_neighbor_tour_balanced_cut
  import nntbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [23:0] runtime,
  input  logic [15:0] coord_0,
  input  logic [15:0] coord_1,
  input  logic [15:0] coord_2,
  input  logic [15:0] coord_3,
  input  logic [15:0] coord_4,
  input  logic [15:0] coord_5,
  input  logic [15:0] coord_6,
  input  logic [15:0] coord_7,
  input  logic        last_job,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  job_number,
  output logic [5:0]  stage,
  output logic        stage_end,
  output logic        last_result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  cmd_t cmd;
  status_t sts;
  logic [MaxDims-1:0][15:0] coords;
  logic in_last;
  logic sts_full;
  logic [6:0] loaded;

  assign coords = {coord_7, coord_6, coord_5, coord_4, coord_3, coord_2, coord_1, coord_0};
  assign in_last = last_job || sts_full;
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
    end else if (out_valid && !out_stall && last_result) begin
      loaded <= '0;
    end else if (in_valid && !in_stall) begin
      loaded <= loaded + 7'd1;
    end
  end
  assign sts_full = (loaded == 7'(MaxItems - 1));

  nntbc_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_last, .out_stall, .sts,
    .in_stall, .out_valid, .cmd
  );

  nntbc_dp u_dp (
    .clk, .rst, .cmd, .cfg_we, .cfg_index, .cfg_data, .runtime, .coords,
    .sts, .job_number, .stage, .stage_end, .last_result
  );

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb
  import nntbc_pkg::*;
;

  typedef struct {
    logic [6:0] job_number;
    logic [5:0] stage;
    logic       stage_end;
    logic       last_result;
  } tour_word_t;

  class stage_plan_board;
    logic [6:0]  num_stages = 1;
    logic [3:0]  num_dims = 1;
    logic [23:0] job_runtime[MaxItems];
    shortint     job_point[MaxItems][MaxDims];
    int          jobs_held = 0;
    longint unsigned load_sum = 0;
    tour_word_t  expected_words[$];
    int          mismatches = 0;

    function void load_job(logic [23:0] rt, logic [7:0][15:0] pt, bit fin);
      bit seen[MaxItems];
      int order[MaxItems];
      int n, cur, pick, stages, dims, stage_now;
      bit found, cut;
      longint unsigned best, d, target, seg;
      longint df;
      tour_word_t w;
      if (jobs_held >= MaxItems) begin
        jobs_held = 0;
        load_sum = 0;
      end
      job_runtime[jobs_held] = rt;
      for (int k = 0; k < MaxDims; k++) job_point[jobs_held][k] = pt[k];
      load_sum += rt;
      jobs_held++;
      if (!fin && jobs_held < MaxItems) return;
      n = jobs_held;
      stages = (num_stages == 0) ? 1 : (num_stages > 64 ? 64 : num_stages);
      dims = (num_dims > MaxDims) ? MaxDims : num_dims;
      foreach (seen[j]) seen[j] = 0;
      cur = 0;
      seen[0] = 1;
      order[0] = 0;
      for (int i = 1; i < n; i++) begin
        found = 0;
        best = 0;
        pick = 0;
        for (int j = 0; j < n; j++) begin
          if (!seen[j]) begin
            d = 0;
            for (int k = 0; k < dims; k++) begin
              df = longint'(job_point[cur][k]) - longint'(job_point[j][k]);
              d += df * df;
            end
            if (!found || d < best) begin
              best = d;
              pick = j;
              found = 1;
            end
          end
        end
        seen[pick] = 1;
        order[i] = pick;
        cur = pick;
      end
      target = (load_sum + stages - 1) / stages;
      seg = 0;
      stage_now = 0;
      for (int i = 0; i < n; i++) begin
        seg += job_runtime[order[i]];
        cut = stage_now < stages - 1 && seg >= target && (n - 1 - i) > (stages - 1 - stage_now);
        w.job_number = 7'(order[i] + 1);
        w.stage = 6'(stage_now);
        w.stage_end = cut || i == n - 1;
        w.last_result = i == n - 1;
        expected_words = {expected_words, w};
        if (cut) begin
          stage_now++;
          seg = 0;
        end
      end
      jobs_held = 0;
      load_sum = 0;
    endfunction

    function void check_word(tour_word_t got);
      tour_word_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: job %0d stage %0d end %0b last %0b",
                   got.job_number, got.stage, got.stage_end, got.last_result);
        return;
      end
      want = expected_words.pop_front();
      if (got.job_number !== want.job_number || got.stage !== want.stage ||
          got.stage_end !== want.stage_end || got.last_result !== want.last_result) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected job %0d stage %0d end %0b last %0b, got %0d %0d %0b %0b",
                   want.job_number, want.stage, want.stage_end, want.last_result,
                   got.job_number, got.stage, got.stage_end, got.last_result);
      end
    endfunction
  endclass

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [23:0] runtime;
  logic [7:0][15:0] point;
  logic last_job;
  logic [6:0] job_number;
  logic [5:0] stage;
  logic stage_end, last_result;
  logic cfg_we, cfg_index;
  logic [6:0] cfg_data;

  stage_plan_board board = new();
  bit calm = 0;
  bit send_gaps = 1;
  bit recv_gaps = 1;
  int stall_run = 0;
  int quiet_cycles = 0;
  int jobs_sent = 0;

  nearest_neighbor_tour_balanced_cut DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .runtime(runtime),
    .coord_0(point[0]), .coord_1(point[1]), .coord_2(point[2]), .coord_3(point[3]),
    .coord_4(point[4]), .coord_5(point[5]), .coord_6(point[6]), .coord_7(point[7]),
    .last_job(last_job),
    .out_valid(out_valid), .out_stall(out_stall),
    .job_number(job_number), .stage(stage), .stage_end(stage_end),
    .last_result(last_result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (stall_run > 0) begin
      out_stall <= 1;
      stall_run <= stall_run - 1;
    end else if (!calm && recv_gaps && $urandom_range(0, 5) == 0) begin
      out_stall <= 1;
      stall_run <= $urandom_range(0, 5);
    end else begin
      out_stall <= 0;
    end
  end

  always @(posedge clk) begin
    tour_word_t got;
    if (!rst && out_valid && !out_stall) begin
      got.job_number = job_number;
      got.stage = stage;
      got.stage_end = stage_end;
      got.last_result = last_result;
      board.check_word(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 300000) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic idx, input logic [6:0] value);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    if (idx == CfgNumStages) board.num_stages = value;
    else board.num_dims = value[3:0];
  endtask

  task automatic wait_for_results();
    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_regs(input logic [6:0] stages_val, input logic [3:0] dims_val);
    wait_for_results();
    write_reg(CfgNumStages, stages_val);
    write_reg(CfgNumDims, {3'b000, dims_val});
    cfg_we <= 0;
  endtask

  task automatic push_job(input logic [23:0] rt, input logic [7:0][15:0] pt, input bit fin);
    if (!calm && send_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    runtime <= rt;
    point <= pt;
    last_job <= fin;
    do @(posedge clk); while (in_stall);
    board.load_job(rt, pt, fin);
    jobs_sent++;
  endtask

  // Coordinate styles: 0 full random, 1 tiny range for ties, 2 extremes, 3 all equal.
  task automatic send_set(input int n, input int style, input bit flag_full);
    logic [7:0][15:0] pt;
    logic [23:0] rt;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < MaxDims; k++) begin
        case (style)
          0: pt[k] = 16'($urandom);
          1: pt[k] = 16'($urandom_range(0, 3) - 1);
          2: pt[k] = ($urandom_range(0, 2) == 0) ? 16'h8000 :
                     ($urandom_range(0, 1) ? 16'h7fff : 16'h0000);
          default: pt[k] = 16'h1234;
        endcase
      end
      case ($urandom_range(0, 4))
        0: rt = 24'h000000;
        1: rt = 24'hffffff;
        2: rt = 24'($urandom);
        default: rt = 24'($urandom_range(0, 50));
      endcase
      push_job(rt, pt, (i == n - 1) && (n < MaxItems || flag_full));
    end
    in_valid <= 0;
    @(posedge clk);
  endtask

  initial begin
    int n;
    rst <= 1;
    in_valid <= 0;
    runtime <= '0;
    point <= '0;
    last_job <= 0;
    cfg_we <= 0;
    cfg_index <= CfgNumStages;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send_set(1, 2, 1);
    send_set(4, 2, 1);
    set_regs(7'd0, 4'd15);
    send_set(3, 3, 1);
    set_regs(7'd127, 4'd0);
    send_set(5, 0, 1);
    set_regs(7'd64, 4'd8);
    send_set(6, 1, 1);
    set_regs(7'd2, 4'd3);
    send_set(4, 0, 1);

    while (jobs_sent < 470) begin
      if (jobs_sent > 400) calm = 1;
      send_gaps = $urandom_range(0, 3) != 0;
      recv_gaps = $urandom_range(0, 3) != 0;
      if (!calm) begin
        if ($urandom_range(0, 3) == 0) begin
          set_regs(7'($urandom_range(0, 5) == 0 ? $urandom_range(0, 127) : $urandom_range(1, 8)),
                   4'($urandom_range(0, 15)));
        end else if ($urandom_range(0, 5) == 0) begin
          wait_for_results();
        end
      end
      n = (jobs_sent < 400 && $urandom_range(0, 24) == 0) ? MaxItems : $urandom_range(1, 9);
      send_set(n, $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3),
               1'($urandom_range(0, 1)));
    end

    while (board.expected_words.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.mismatches == 0 && board.expected_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
